// ===== sv/plc_pkg.sv =====
package plc_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int ALPHA_W   = 17;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int MODE_W    = 2;

  localparam int NUM_CH     = 3;
  localparam int DEN_W      = 33;   // over: A up to 2^32
  localparam int NUM_W      = 49;   // rounded numerator, below 2^49
  localparam int DIV_STAGES = SAMPLE_W;
  // A, B, C, D, E, divider stages, output register
  localparam int LATENCY    = 5 + DIV_STAGES + 1;

  localparam logic [ALPHA_W-1:0]  ALPHA_ONE  = 17'd65536;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'hFFFF;

  localparam logic [MODE_W-1:0] MODE_OVER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MASK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MUL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MUL_DIV    = 1'd1;

  localparam logic [CFG_DATA_W-1:0] MUL_DIV_RESET = 16'd255;

  // what the result of one pixel comes from
  typedef enum logic [1:0] {
    KIND_BOT = 2'd0,
    KIND_TOP = 2'd1,
    KIND_DIV = 2'd2
  } kind_t;

  function automatic logic [ALPHA_W-1:0] clamp_alpha(input logic [ALPHA_W-1:0] a);
    return (a[ALPHA_W-1] && (|a[ALPHA_W-2:0])) ? ALPHA_ONE : a;
  endfunction

endpackage

// ===== sv/pixel_layer_compositor_core.sv =====
// Pixel layer compositor: blends a top pixel onto a bottom pixel.
// Input: one pixel pair per transaction on the in_* ports, taken at a clock
// edge where start is high and busy is low. busy is always low, so a new
// pixel pair can be given in every cycle.
// Configuration: cfg_we / cfg_index / cfg_wdata write blend_mode (index 0)
// or multiply_divisor (index 1); write only while no pixel is in flight.
// Output: each result is shown for exactly one cycle with out_valid high,
// in input order.
// Throughput: one pixel per clock. Latency is set by the input register,
// the two multiplier stages, the numerator/rounding stage, the saturation
// check and a 16-stage restoring divider that retires one quotient bit per
// stage, one lane per color channel, plus the output register.
// Reset (synchronous, rst_n low) clears all in-flight pixels and restores
// blend_mode 0 and multiply_divisor 255.
// The receiver cannot stall, so there is no back-pressure path.
module pixel_layer_compositor_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [plc_pkg::SAMPLE_W-1:0]    in_bottom_red,
  input  logic [plc_pkg::SAMPLE_W-1:0]    in_bottom_green,
  input  logic [plc_pkg::SAMPLE_W-1:0]    in_bottom_blue,
  input  logic [plc_pkg::ALPHA_W-1:0]     in_bottom_alpha,
  input  logic [plc_pkg::SAMPLE_W-1:0]    in_top_red,
  input  logic [plc_pkg::SAMPLE_W-1:0]    in_top_green,
  input  logic [plc_pkg::SAMPLE_W-1:0]    in_top_blue,
  input  logic [plc_pkg::ALPHA_W-1:0]     in_top_alpha,
  input  logic                            in_top_valid,
  input  logic                            in_line_end,
  input  logic                            cfg_we,
  input  logic [plc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [plc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic                            out_valid,
  output logic [plc_pkg::SAMPLE_W-1:0]    out_red,
  output logic [plc_pkg::SAMPLE_W-1:0]    out_green,
  output logic [plc_pkg::SAMPLE_W-1:0]    out_blue,
  output logic [plc_pkg::ALPHA_W-1:0]     out_alpha,
  output logic                            out_line_end
);
  import plc_pkg::*;

  // configuration
  logic [MODE_W-1:0]     mode_r;
  logic [CFG_DATA_W-1:0] mdiv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_OVER;
      mdiv_r <= MUL_DIV_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLEND_MODE: mode_r <= cfg_wdata[MODE_W-1:0];
        REG_MUL_DIV:    mdiv_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---------------- stage A: clamp and decode ----------------
  logic [SAMPLE_W-1:0] in_bot [NUM_CH];
  logic [SAMPLE_W-1:0] in_top [NUM_CH];
  logic [ALPHA_W-1:0]  ab_nxt, at_nxt;
  kind_t               kind_nxt;

  assign in_bot[0] = in_bottom_red;
  assign in_bot[1] = in_bottom_green;
  assign in_bot[2] = in_bottom_blue;
  assign in_top[0] = in_top_red;
  assign in_top[1] = in_top_green;
  assign in_top[2] = in_top_blue;
  assign ab_nxt = clamp_alpha(in_bottom_alpha);
  assign at_nxt = clamp_alpha(in_top_alpha);

  always_comb begin
    kind_nxt = KIND_BOT;
    case (mode_r)
      MODE_OVER: begin
        if (in_top_valid && at_nxt != '0) begin
          kind_nxt = (ab_nxt == '0) ? KIND_TOP : KIND_DIV;
        end
      end
      MODE_MASK: begin
        if (in_top_valid) kind_nxt = KIND_TOP;
      end
      MODE_MUL: begin
        if (in_top_valid) kind_nxt = KIND_DIV;
      end
      default: kind_nxt = KIND_BOT;
    endcase
  end

  logic                v_a_r, v_b_r, v_c_r, v_d_r;
  logic [SAMPLE_W-1:0] bot_a_r [NUM_CH];
  logic [SAMPLE_W-1:0] top_a_r [NUM_CH];
  logic [ALPHA_W-1:0]  ab_a_r, at_a_r;
  kind_t               kind_a_r;
  logic                mul_a_r, le_a_r;
  logic [SAMPLE_W-1:0] d_a_r;

  always_ff @(posedge clk) begin
    bot_a_r  <= in_bot;
    top_a_r  <= in_top;
    ab_a_r   <= ab_nxt;
    at_a_r   <= at_nxt;
    kind_a_r <= kind_nxt;
    mul_a_r  <= (mode_r == MODE_MUL);
    le_a_r   <= in_line_end;
    d_a_r    <= (mdiv_r == '0) ? 16'd1 : mdiv_r;
  end

  // ---------------- stage B: first products ----------------
  logic [SAMPLE_W-1:0] bot_b_r [NUM_CH];
  logic [SAMPLE_W-1:0] top_b_r [NUM_CH];
  logic [DEN_W-1:0]    p_b_r [NUM_CH];   // at*top, or bot*top in multiply mode
  logic [DEN_W-1:0]    wb_b_r, pa_b_r;
  logic [ALPHA_W-1:0]  ab_b_r, at_b_r;
  kind_t               kind_b_r;
  logic                mul_b_r, le_b_r;
  logic [SAMPLE_W-1:0] d_b_r;
  logic [ALPHA_W-1:0]  inv_at;

  assign inv_at = ALPHA_ONE - at_a_r;

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) begin
      p_b_r[c] <= DEN_W'((mul_a_r ? {1'b0, bot_a_r[c]} : at_a_r) * top_a_r[c]);
    end
    wb_b_r   <= DEN_W'(ab_a_r * inv_at);
    pa_b_r   <= DEN_W'(ab_a_r * at_a_r);
    bot_b_r  <= bot_a_r;
    top_b_r  <= top_a_r;
    ab_b_r   <= ab_a_r;
    at_b_r   <= at_a_r;
    kind_b_r <= kind_a_r;
    mul_b_r  <= mul_a_r;
    le_b_r   <= le_a_r;
    d_b_r    <= d_a_r;
  end

  // ---------------- stage C: bottom weights and new alpha ----------------
  logic [SAMPLE_W-1:0] bot_c_r [NUM_CH];
  logic [SAMPLE_W-1:0] top_c_r [NUM_CH];
  logic [DEN_W-1:0]    p_c_r [NUM_CH];
  logic [NUM_W-1:0]    wbb_c_r [NUM_CH];
  logic [DEN_W-1:0]    big_a_c_r, pa_c_r;
  logic [ALPHA_W-1:0]  ab_c_r, at_c_r;
  kind_t               kind_c_r;
  logic                mul_c_r, le_c_r;
  logic [SAMPLE_W-1:0] d_c_r;

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) begin
      wbb_c_r[c] <= NUM_W'(wb_b_r * bot_b_r[c]);
    end
    big_a_c_r <= DEN_W'({at_b_r, 16'd0}) + wb_b_r;
    p_c_r     <= p_b_r;
    pa_c_r    <= pa_b_r;
    bot_c_r   <= bot_b_r;
    top_c_r   <= top_b_r;
    ab_c_r    <= ab_b_r;
    at_c_r    <= at_b_r;
    kind_c_r  <= kind_b_r;
    mul_c_r   <= mul_b_r;
    le_c_r    <= le_b_r;
    d_c_r     <= d_b_r;
  end

  // ---------------- stage D: rounded numerator, bypass values ----------------
  logic [NUM_W-1:0]    nr_d_r [NUM_CH];
  logic [DEN_W-1:0]    den_d_r;
  logic [SAMPLE_W-1:0] byp_d_r [NUM_CH];
  logic [ALPHA_W-1:0]  alpha_d_r;
  kind_t               kind_d_r;
  logic                le_d_r;
  logic [DEN_W-1:0]    den_nxt;
  logic [DEN_W:0]      alpha_sum;
  logic [NUM_W-1:0]    num_nxt [NUM_CH];

  assign den_nxt = mul_c_r ? DEN_W'(d_c_r) : big_a_c_r;
  assign alpha_sum = (mul_c_r ? {1'b0, pa_c_r} : {1'b0, big_a_c_r}) + (DEN_W+1)'(32768);

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      num_nxt[c] = mul_c_r ? NUM_W'(p_c_r[c])
                           : NUM_W'({p_c_r[c], 16'd0}) + wbb_c_r[c];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) begin
      nr_d_r[c]  <= num_nxt[c] + NUM_W'(den_nxt >> 1);
      byp_d_r[c] <= (kind_c_r == KIND_TOP) ? top_c_r[c] : bot_c_r[c];
    end
    case (kind_c_r)
      KIND_TOP: alpha_d_r <= at_c_r;
      KIND_DIV: alpha_d_r <= alpha_sum[ALPHA_W+15:16];
      default:  alpha_d_r <= ab_c_r;
    endcase
    den_d_r  <= den_nxt;
    kind_d_r <= kind_c_r;
    le_d_r   <= le_c_r;
  end

  // ---------------- stage E: saturation check ----------------
  // divider stage index 0 is stage E
  logic [NUM_W-1:0]    rem_r  [DIV_STAGES+1][NUM_CH];
  logic [SAMPLE_W-1:0] quo_r  [DIV_STAGES+1][NUM_CH];
  logic [NUM_CH-1:0]   sat_r  [DIV_STAGES+1];
  logic [SAMPLE_W-1:0] byp_r  [DIV_STAGES+1][NUM_CH];
  logic [DEN_W-1:0]    den_r  [DIV_STAGES+1];
  logic [ALPHA_W-1:0]  alpha_r [DIV_STAGES+1];
  kind_t               kind_r [DIV_STAGES+1];
  logic                le_r   [DIV_STAGES+1];
  logic [DIV_STAGES:0] v_div_r;

  logic [NUM_W-1:0] rem_nxt [DIV_STAGES+1][NUM_CH];
  logic             qbit_nxt [DIV_STAGES+1][NUM_CH];

  always_comb begin
    logic [NUM_W:0] trial;
    for (int s = 0; s <= DIV_STAGES; s++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        rem_nxt[s][c]  = '0;
        qbit_nxt[s][c] = 1'b0;
      end
    end
    // stage s (1..16) resolves quotient bit 16-s
    for (int s = 1; s <= DIV_STAGES; s++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        trial = {1'b0, rem_r[s-1][c]}
              - ((NUM_W+1)'(den_r[s-1]) << (DIV_STAGES - s));
        qbit_nxt[s][c] = !trial[NUM_W];
        rem_nxt[s][c]  = trial[NUM_W] ? rem_r[s-1][c] : trial[NUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) begin
      sat_r[0][c] <= (nr_d_r[c] >= {den_d_r, 16'd0});
      rem_r[0][c] <= nr_d_r[c];
      quo_r[0][c] <= '0;
      byp_r[0][c] <= byp_d_r[c];
    end
    den_r[0]   <= den_d_r;
    alpha_r[0] <= alpha_d_r;
    kind_r[0]  <= kind_d_r;
    le_r[0]    <= le_d_r;
    for (int s = 1; s <= DIV_STAGES; s++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        rem_r[s][c] <= rem_nxt[s][c];
        quo_r[s][c] <= quo_r[s-1][c] |
                       (SAMPLE_W'(qbit_nxt[s][c]) << (DIV_STAGES - s));
        byp_r[s][c] <= byp_r[s-1][c];
      end
      sat_r[s]   <= sat_r[s-1];
      den_r[s]   <= den_r[s-1];
      alpha_r[s] <= alpha_r[s-1];
      kind_r[s]  <= kind_r[s-1];
      le_r[s]    <= le_r[s-1];
    end
  end

  // ---------------- output register ----------------
  logic [SAMPLE_W-1:0] res_nxt [NUM_CH];
  logic [SAMPLE_W-1:0] res_r [NUM_CH];
  logic [ALPHA_W-1:0]  ra_r;
  logic                le_o_r, v_o_r;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (kind_r[DIV_STAGES] == KIND_DIV) begin
        res_nxt[c] = sat_r[DIV_STAGES][c] ? SAMPLE_MAX : quo_r[DIV_STAGES][c];
      end else begin
        res_nxt[c] = byp_r[DIV_STAGES][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    ra_r   <= alpha_r[DIV_STAGES];
    le_o_r <= le_r[DIV_STAGES];
  end

  // valid bits; v_div_r[s] goes with divider stage s
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r   <= 1'b0;
      v_b_r   <= 1'b0;
      v_c_r   <= 1'b0;
      v_d_r   <= 1'b0;
      v_div_r <= '0;
      v_o_r   <= 1'b0;
    end else begin
      v_a_r   <= accept;
      v_b_r   <= v_a_r;
      v_c_r   <= v_b_r;
      v_d_r   <= v_c_r;
      v_div_r <= {v_div_r[DIV_STAGES-1:0], v_d_r};
      v_o_r   <= v_div_r[DIV_STAGES];
    end
  end

  assign out_valid    = v_o_r;
  assign out_red      = res_r[0];
  assign out_green    = res_r[1];
  assign out_blue     = res_r[2];
  assign out_alpha    = ra_r;
  assign out_line_end = le_o_r;

  // ---------------- checks ----------------
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without matching transaction");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (v_div_r[0] && kind_r[0] == KIND_DIV) |-> den_r[0] != '0)
    else $error("zero divisor entered divider");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (v_div_r[DIV_STAGES] && kind_r[DIV_STAGES] == KIND_DIV && !sat_r[DIV_STAGES][0])
      |-> rem_r[DIV_STAGES][0] < NUM_W'(den_r[DIV_STAGES]))
    else $error("divider remainder not reduced");

  a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_alpha <= ALPHA_ONE)
    else $error("alpha above one");

endmodule
